FILE: rtl/assert_macros.svh
// Assertion macros for the checker module mlh_checker.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define MLH_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define MLH_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/mlh_pkg.sv
// Shared constants, types and codes for the multilinear hash engine.
// No dependencies; every other RTL file except assert_macros.svh imports this package.
`default_nettype none

package mlh_pkg;

  localparam int KEY_WORDS   = 64;
  localparam int KEY_AW      = $clog2(KEY_WORDS);
  localparam int KEY_W       = 64;
  localparam int HALF_W      = KEY_W / 2;
  localparam int KEY_INDEX_W = 6;
  localparam int WORD_W      = 32;
  localparam int WORD_BYTES  = WORD_W / 8;
  localparam int CNT_W       = 3;
  localparam int LEN_W       = 32;
  localparam int HASH_W      = 32;

  localparam int CHUNK_WORDS = 8;
  localparam int CHUNK_BYTES = WORD_BYTES * CHUNK_WORDS;
  localparam int CHUNK_LG    = $clog2(CHUNK_BYTES);

  // Result buffer; also bounds the number of results in flight.
  localparam int OUT_DEPTH = 4;
  localparam int OUT_AW    = $clog2(OUT_DEPTH);
  localparam int PEND_W    = $clog2(OUT_DEPTH + 1);

  localparam logic [CNT_W-1:0] FULL_WORD_BYTES = CNT_W'(WORD_BYTES);

  typedef enum logic {
    OP_KEY_LOAD = 1'b0,
    OP_DATA     = 1'b1
  } op_t;

  typedef logic [KEY_AW-1:0] key_addr_t;

  typedef struct packed {
    logic             we;
    key_addr_t        waddr;
    logic [KEY_W-1:0] wdata;
    key_addr_t        raddr_a;
    key_addr_t        raddr_b;
  } ram_req_t;

  typedef struct packed {
    logic              valid;
    logic              last;
    logic [WORD_W-1:0] word;
    logic [LEN_W-1:0]  length;
  } mac_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/mlh_msg_if.sv
// Input word channel: valid/ready handshake plus the message/key payload.
// Depends on mlh_pkg for field widths.
`default_nettype none

interface mlh_msg_if;
  import mlh_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   operation;
  logic [KEY_INDEX_W-1:0] key_index;
  logic [KEY_W-1:0]       key_value;
  logic [WORD_W-1:0]      data_word;
  logic [CNT_W-1:0]       byte_count;
  logic                   last_word;

  modport source (
    output valid, operation, key_index, key_value, data_word, byte_count, last_word,
    input  ready
  );

  modport sink (
    input  valid, operation, key_index, key_value, data_word, byte_count, last_word,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/mlh_res_if.sv
// Result channel: valid/ready handshake plus the 32-bit hash value.
// Depends on mlh_pkg for the field width.
`default_nettype none

interface mlh_res_if;
  import mlh_pkg::*;

  logic              valid;
  logic              ready;
  logic [HASH_W-1:0] hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink   (input valid, hash_value, output ready);
endinterface

`default_nettype wire

FILE: rtl/mlh_key_ram.sv
// Key table: one write port, two read ports, registered read data.
// Depends on mlh_pkg.
`default_nettype none

module mlh_key_ram (
  input  logic                      clk,
  input  mlh_pkg::ram_req_t         req,
  output logic [mlh_pkg::KEY_W-1:0] rd_a,
  output logic [mlh_pkg::KEY_W-1:0] rd_b
);
  import mlh_pkg::*;

  logic [KEY_W-1:0] mem [KEY_WORDS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_a <= mem[req.raddr_a];
    rd_b <= mem[req.raddr_b];
  end
endmodule

`default_nettype wire

FILE: rtl/mlh_seq.sv
// Front end: input handshake, word masking, position and length counters,
// key table addressing and the count of outstanding results. Depends on mlh_pkg and mlh_msg_if.
`default_nettype none

module mlh_seq (
  input  logic              clk,
  input  logic              rst,
  mlh_msg_if.sink           msg,
  input  logic              pop,
  output mlh_pkg::ram_req_t ram,
  output mlh_pkg::mac_cmd_t cmd
);
  import mlh_pkg::*;

  key_addr_t         position;
  logic [LEN_W-1:0]  length;
  logic              tail;
  key_addr_t         tail_addr;
  logic [PEND_W-1:0] pending;

  logic              cmd_valid;
  logic              cmd_last;
  logic [WORD_W-1:0] cmd_word;
  logic [LEN_W-1:0]  cmd_length;

  logic              accept;
  logic              is_data;
  logic              is_last;
  logic [CNT_W-1:0]  cnt_eff;
  logic [WORD_W-1:0] word_masked;
  logic [LEN_W-1:0]  length_next;
  logic [LEN_W:0]    round_up;
  key_addr_t         k_addr;

  // Hold off during reset, during the extra key read of a final word and when the
  // result buffer could not absorb another result.
  assign msg.ready = !rst && !tail && (pending < PEND_W'(OUT_DEPTH));

  assign accept  = msg.valid && msg.ready;
  assign is_data = (msg.operation == OP_DATA);
  assign is_last = is_data && msg.last_word;

  always_comb begin
    cnt_eff = (msg.byte_count > FULL_WORD_BYTES) ? FULL_WORD_BYTES : msg.byte_count;
    for (int b = 0; b < WORD_BYTES; b++) begin
      word_masked[8*b +: 8] = (CNT_W'(b) < cnt_eff) ? msg.data_word[8*b +: 8] : 8'h00;
    end
    length_next = length + LEN_W'(cnt_eff);
    round_up    = {1'b0, length_next} + (LEN_W+1)'(CHUNK_BYTES - 1);
    // chunk count times chunk size, wrapped to the table
    k_addr      = KEY_AW'(round_up[CHUNK_LG +: KEY_AW] * KEY_AW'(CHUNK_WORDS));
  end

  always_comb begin
    ram.we      = accept && !is_data;
    ram.waddr   = KEY_AW'(msg.key_index);
    ram.wdata   = msg.key_value;
    ram.raddr_a = tail ? tail_addr : position;
    ram.raddr_b = k_addr;
  end

  assign cmd = '{valid: cmd_valid, last: cmd_last, word: cmd_word, length: cmd_length};

  always_ff @(posedge clk) begin
    if (rst) begin
      position  <= '0;
      length    <= '0;
      tail      <= 1'b0;
      pending   <= '0;
      cmd_valid <= 1'b0;
    end else begin
      tail      <= accept && is_last;
      cmd_valid <= accept && is_data;
      if (accept && is_data) begin
        if (is_last) begin
          position <= '0;
          length   <= '0;
        end else begin
          position <= position + 1'b1;
          length   <= length_next;
        end
      end
      if ((accept && is_last) && !pop) begin
        pending <= pending + 1'b1;
      end else if (!(accept && is_last) && pop) begin
        pending <= pending - 1'b1;
      end
    end
    if (accept && is_last) begin
      tail_addr <= k_addr + 1'b1;
    end
    cmd_last   <= is_last;
    cmd_word   <= word_masked;
    cmd_length <= length_next;
  end
endmodule

`default_nettype wire

FILE: rtl/mlh_mac.sv
// Multiply-accumulate datapath: split 64x32 products, accumulator and the
// final length term. Depends on mlh_pkg; fed by mlh_seq and mlh_key_ram.
`default_nettype none

module mlh_mac (
  input  logic                       clk,
  input  logic                       rst,
  input  mlh_pkg::mac_cmd_t          cmd,
  input  logic [mlh_pkg::KEY_W-1:0]  key_a,
  input  logic [mlh_pkg::KEY_W-1:0]  key_b,
  output logic                       push,
  output logic [mlh_pkg::HASH_W-1:0] push_hash
);
  import mlh_pkg::*;

  logic              s2_valid;
  logic              s2_last;
  logic [KEY_W-1:0]  p_lo;
  logic [HALF_W-1:0] p_hi;
  logic [KEY_W-1:0]  q_lo;
  logic [HALF_W-1:0] q_hi;

  logic [KEY_W-1:0]  acc;
  logic              s3_valid;
  logic [KEY_W-1:0]  s3_sum;
  logic [KEY_W-1:0]  fin;

  logic [KEY_W-1:0]  term;
  logic [KEY_W-1:0]  acc_sum;
  logic [KEY_W-1:0]  len_term;
  logic [KEY_W-1:0]  total;

  // Stage 1: key_a = key[position], key_b = key[k]; low 64 bits only.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= cmd.valid;
    end
    s2_last <= cmd.last;
    p_lo    <= key_a[HALF_W-1:0] * cmd.word;
    p_hi    <= key_a[KEY_W-1:HALF_W] * cmd.word;
    q_lo    <= key_b[HALF_W-1:0] * cmd.length;
    q_hi    <= key_b[KEY_W-1:HALF_W] * cmd.length;
  end

  always_comb begin
    term     = {p_lo[KEY_W-1:HALF_W] + p_hi, p_lo[HALF_W-1:0]};
    acc_sum  = acc + term;
    len_term = {q_lo[KEY_W-1:HALF_W] + q_hi, q_lo[HALF_W-1:0]};
    total    = s3_sum + fin;
  end

  // Stage 2: key_a now holds key[k+1] for a final word.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid && s2_last;
      if (s2_valid) begin
        acc <= s2_last ? '0 : acc_sum;
      end
    end
    s3_sum <= acc_sum;
    fin    <= len_term + key_a;
  end

  assign push      = s3_valid;
  assign push_hash = total[KEY_W-1:HASH_W];
endmodule

`default_nettype wire

FILE: rtl/mlh_out_fifo.sv
// Result buffer driving the output channel.
// Depends on mlh_pkg and mlh_res_if.
`default_nettype none

module mlh_out_fifo (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [mlh_pkg::HASH_W-1:0] push_hash,
  mlh_res_if.source                  result,
  output logic                       pop
);
  import mlh_pkg::*;

  logic [HASH_W-1:0] slots [OUT_DEPTH];
  logic [OUT_AW-1:0] wr_ptr;
  logic [OUT_AW-1:0] rd_ptr;
  logic [PEND_W-1:0] count;

  assign result.valid      = (count != '0);
  assign result.hash_value = slots[rd_ptr];
  assign pop               = result.valid && result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (!push && pop) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      slots[wr_ptr] <= push_hash;
    end
  end
endmodule

`default_nettype wire

FILE: rtl/multilinear_hash_engine_core.sv
// Multilinear hash engine, top level.
// Depends on mlh_pkg, mlh_msg_if, mlh_res_if, mlh_key_ram, mlh_seq, mlh_mac, mlh_out_fifo.
//
// msg carries one word per handshake: a key load (operation 0) writes
// key_value into entry key_index; a data word (operation 1) carries four
// little-endian bytes, byte_count of them valid. Key loads may arrive at any
// time, also in the middle of a message. The data word with last_word set closes
// the message and produces one hash_value on result.
// Throughput: one word per cycle while msg.ready is high. After a final word, port A
// fetches key[k+1] (the second read port supplied key[k]) and msg.ready stays low.
// A final word's hash_value reaches result through the mlh_seq command register,
// the mlh_mac stage registers and the result buffer.
// Reset clears message state and the result buffer; the key table keeps its
// contents and must be loaded before use. msg.ready is low during reset.
// When result stalls, up to four results wait in the buffer while message
// words continue; msg.ready drops once four results are outstanding.
`default_nettype none

module multilinear_hash_engine_core (
  input  logic      clk,
  input  logic      rst,
  mlh_msg_if.sink   msg,
  mlh_res_if.source result
);
  import mlh_pkg::*;

  ram_req_t          ram;
  mac_cmd_t          cmd;
  logic [KEY_W-1:0]  key_a;
  logic [KEY_W-1:0]  key_b;
  logic              push;
  logic [HASH_W-1:0] push_hash;
  logic              pop;

  mlh_seq u_seq (
    .clk (clk),
    .rst (rst),
    .msg (msg),
    .pop (pop),
    .ram (ram),
    .cmd (cmd)
  );

  mlh_key_ram u_key_ram (
    .clk  (clk),
    .req  (ram),
    .rd_a (key_a),
    .rd_b (key_b)
  );

  mlh_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .key_a     (key_a),
    .key_b     (key_b),
    .push      (push),
    .push_hash (push_hash)
  );

  mlh_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_hash (push_hash),
    .result    (result),
    .pop       (pop)
  );
endmodule

`default_nettype wire

FILE: rtl/mlh_checker.sv
// Port-level checks for multilinear_hash_engine_core, attached by bind.
// Depends on assert_macros.svh and mlh_pkg.
`default_nettype none
`include "assert_macros.svh"

module mlh_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       msg_valid,
  input wire logic                       msg_ready,
  input wire logic                       msg_operation,
  input wire logic                       msg_last_word,
  input wire logic                       result_valid,
  input wire logic                       result_ready,
  input wire logic [mlh_pkg::HASH_W-1:0] result_hash
);
  import mlh_pkg::*;

  logic last_taken;

  assign last_taken = msg_valid && msg_ready && (msg_operation == OP_DATA) && msg_last_word;

  `MLH_ASSERT_NXT(a_result_hold, result_valid && !result_ready, result_valid, "result dropped while stalled")
  `MLH_ASSERT_NXT(a_result_stable, result_valid && !result_ready, $stable(result_hash), "hash changed while stalled")
  // the final word needs a second key read, so the next cycle takes no word
  `MLH_ASSERT_NXT(a_tail_stall, last_taken, !msg_ready, "word taken during final key read")
  // an empty buffer fills only from a final word that has passed the seq and mac registers
  `MLH_ASSERT_IMP(a_result_origin, $rose(result_valid), $past(last_taken, 4), "result without final word")
endmodule

bind multilinear_hash_engine_core mlh_checker u_mlh_checker (
  .clk           (clk),
  .rst           (rst),
  .msg_valid     (msg.valid),
  .msg_ready     (msg.ready),
  .msg_operation (msg.operation),
  .msg_last_word (msg.last_word),
  .result_valid  (result.valid),
  .result_ready  (result.ready),
  .result_hash   (result.hash_value)
);

`default_nettype wire

FILE: dv/mlh_hash_checker.sv
// Scoreboard for multilinear_hash_engine_core: predicts hash_value per message.
// Depends on mlh_pkg, mlh_msg_if and mlh_res_if; watches both channels passively.
module mlh_hash_checker
  import mlh_pkg::*;
(
  input  logic clk,
  input  logic rst,
  mlh_msg_if   msg,
  mlh_res_if   result,
  output int   fail_count,
  output int   pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [LEN_W:0] ROUND_UP = (LEN_W+1)'(CHUNK_BYTES - 1);

  logic [KEY_W-1:0]  key_bank [KEY_WORDS];
  logic [KEY_W-1:0]  acc_sum;
  logic [LEN_W-1:0]  msg_len;
  key_addr_t         word_pos;
  logic [HASH_W-1:0] hash_due_q [$];
  logic [HASH_W-1:0] want_hash;
  int                errs = 0;

  task automatic mix_word(input op_t op, input key_addr_t idx, input logic [KEY_W-1:0] kval,
                          input logic [WORD_W-1:0] word, input logic [CNT_W-1:0] cnt,
                          input logic last);
    logic [CNT_W-1:0]  used;
    logic [WORD_W-1:0] masked;
    logic [LEN_W:0]    chunks;
    key_addr_t         k;
    key_addr_t         k_next;
    logic [KEY_W-1:0]  sum;
    if (op == OP_KEY_LOAD) begin
      key_bank[idx] = kval;
      return;
    end
    // Clamp the byte count to a full word, then zero the unused upper bytes.
    used = (cnt > FULL_WORD_BYTES) ? FULL_WORD_BYTES : cnt;
    masked = word;
    for (int b = 0; b < WORD_BYTES; b++) begin
      if (b >= used) masked[8*b +: 8] = '0;
    end
    acc_sum  = acc_sum + key_bank[word_pos] * KEY_W'(masked);
    msg_len  = msg_len + LEN_W'(used);
    word_pos = word_pos + 1'b1;
    if (!last) return;
    chunks = ({1'b0, msg_len} + ROUND_UP) >> CHUNK_LG;
    k      = key_addr_t'(chunks * CHUNK_WORDS);
    k_next = key_addr_t'(k + 1'b1);
    sum    = key_bank[k] * KEY_W'(msg_len) + key_bank[k_next] + acc_sum;
    hash_due_q.push_back(sum[KEY_W-1 -: HASH_W]);
    acc_sum  = '0;
    msg_len  = '0;
    word_pos = '0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      acc_sum  = '0;
      msg_len  = '0;
      word_pos = '0;
      hash_due_q.delete();
    end else begin
      if (result.valid && result.ready) begin
        if (hash_due_q.size() == 0) begin
          $error("hash_value: expected none, actual %h", result.hash_value);
          errs++;
        end else begin
          want_hash = hash_due_q.pop_front();
          if (result.hash_value !== want_hash) begin
            $error("hash_value: expected %h, actual %h", want_hash, result.hash_value);
            errs++;
          end
        end
      end
      if (msg.valid && msg.ready)
        mix_word(op_t'(msg.operation), key_addr_t'(msg.key_index), msg.key_value,
                 msg.data_word, msg.byte_count, msg.last_word);
    end
    fail_count    <= errs;
    pending_count <= hash_due_q.size();
  end

endmodule

FILE: dv/tb_multilinear_hash_engine_core.sv
// Testbench top for multilinear_hash_engine_core: clock, reset, word stimulus and verdict.
// Depends on mlh_pkg, mlh_msg_if, mlh_res_if, the RTL top and mlh_hash_checker.
module tb_multilinear_hash_engine_core;
  timeunit 1ns;
  timeprecision 1ps;
  import mlh_pkg::*;

  localparam int RUN_ITEMS   = 420;
  localparam int QUIET_TAIL  = 60;
  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst;
  int   cycles = 0;
  int   fails;
  int   pending;
  bit   send_idle  = 1'b0;
  bit   recv_stall = 1'b0;

  mlh_msg_if msg_ch ();
  mlh_res_if res_ch ();

  multilinear_hash_engine_core dut (
    .clk    (clk),
    .rst    (rst),
    .msg    (msg_ch),
    .result (res_ch)
  );

  mlh_hash_checker chk (
    .clk           (clk),
    .rst           (rst),
    .msg           (msg_ch),
    .result        (res_ch),
    .fail_count    (fails),
    .pending_count (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL multilinear_hash_engine_core");
      $finish;
    end
  end

  // Result side: hold ready low in random bursts while stalling is enabled.
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (recv_stall && $urandom_range(0, 5) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
    end
  end

  function automatic logic [KEY_W-1:0] rand_key();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_word(input op_t op, input logic [KEY_INDEX_W-1:0] idx,
                           input logic [KEY_W-1:0] kval, input logic [WORD_W-1:0] word,
                           input logic [CNT_W-1:0] cnt, input logic last);
    if (send_idle && $urandom_range(0, 4) == 0) begin
      msg_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    msg_ch.valid      <= 1'b1;
    msg_ch.operation  <= op;
    msg_ch.key_index  <= idx;
    msg_ch.key_value  <= kval;
    msg_ch.data_word  <= word;
    msg_ch.byte_count <= cnt;
    msg_ch.last_word  <= last;
    do @(posedge clk); while (!msg_ch.ready);
  endtask

  // Unused payload fields carry random values.
  task automatic load_key(input logic [KEY_INDEX_W-1:0] idx, input logic [KEY_W-1:0] kval);
    push_word(OP_KEY_LOAD, idx, kval, $urandom, CNT_W'($urandom), 1'($urandom));
  endtask

  task automatic send_data(input logic [WORD_W-1:0] word, input logic [CNT_W-1:0] cnt,
                           input logic last);
    push_word(OP_DATA, KEY_INDEX_W'($urandom), {$urandom, $urandom}, word, cnt, last);
  endtask

  initial begin
    int               sent;
    int               msg_words;
    logic [CNT_W-1:0] cnt;
    logic             last;
    rst               <= 1'b1;
    msg_ch.valid      <= 1'b0;
    msg_ch.operation  <= OP_KEY_LOAD;
    msg_ch.key_index  <= '0;
    msg_ch.key_value  <= '0;
    msg_ch.data_word  <= '0;
    msg_ch.byte_count <= '0;
    msg_ch.last_word  <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Fill the whole key table first so no message ever reads an empty entry.
    for (int i = 0; i < KEY_WORDS; i++) load_key(KEY_INDEX_W'(i), rand_key());

    // Directed words.
    load_key(KEY_INDEX_W'(0), '1);
    load_key(KEY_INDEX_W'(1), '1);
    send_data($urandom, CNT_W'(0), 1'b1);                 // empty message
    send_data('1, CNT_W'(4), 1'b0);
    send_data('1, CNT_W'(7), 1'b1);                       // oversized count clamps to four
    load_key(KEY_INDEX_W'(63), '0);
    load_key(KEY_INDEX_W'(0), 64'h8000_0000_0000_0001);
    send_data(32'h1234_5678, CNT_W'(2), 1'b0);            // partial word before the end
    send_data('1, CNT_W'(0), 1'b0);                       // zero bytes, position still moves
    load_key(KEY_INDEX_W'(2), 64'hFFFF_FFFF_0000_0000);   // key write in mid message
    send_data(32'hA5A5_A5A5, CNT_W'(5), 1'b0);
    send_data('0, CNT_W'(6), 1'b0);
    send_data(32'hDEAD_BEEF, CNT_W'(3), 1'b1);
    send_data('1, CNT_W'(1), 1'b1);
    send_data('0, CNT_W'(4), 1'b1);

    // Drain everything before the random part.
    msg_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);

    sent = 0;
    while (sent < RUN_ITEMS) begin
      send_idle  = (sent < RUN_ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
      recv_stall = (sent < RUN_ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 19))
        0:       msg_words = $urandom_range(60, 80);   // may wrap the word position
        1, 2, 3: msg_words = $urandom_range(13, 40);
        default: msg_words = $urandom_range(1, 12);
      endcase
      for (int w = 0; w < msg_words; w++) begin
        if ($urandom_range(0, 11) == 0) begin
          load_key(KEY_INDEX_W'($urandom), rand_key());
          sent++;
        end
        last = (w == msg_words - 1);
        if (last || $urandom_range(0, 7) == 0) cnt = CNT_W'($urandom_range(0, 7));
        else cnt = FULL_WORD_BYTES;
        send_data(rand_word(), cnt, last);
        sent++;
      end
    end

    msg_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (10) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("PASS multilinear_hash_engine_core");
    end else begin
      $display("FAIL multilinear_hash_engine_core");
    end
    $finish;
  end

endmodule
